### rtl/dtir_pkg.sv
// Shared types and constants for the double-to-integer rounding block.
// No dependencies.
package dtir_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned ModeWidth  = 4;
  localparam int unsigned ExpWidth   = 11;
  localparam int unsigned ManWidth   = 52;
  localparam int unsigned SigWidth   = 53;

  // rounding mode codes
  localparam logic [ModeWidth-1:0] ModeHalfUp   = 4'd0;
  localparam logic [ModeWidth-1:0] ModeFloor    = 4'd1;
  localparam logic [ModeWidth-1:0] ModeCeil     = 4'd2;
  localparam logic [ModeWidth-1:0] ModeTrunc    = 4'd3;
  localparam logic [ModeWidth-1:0] ModeAway     = 4'd4;
  localparam logic [ModeWidth-1:0] ModeHalfDown = 4'd5;
  localparam logic [ModeWidth-1:0] ModeHalfZero = 4'd6;
  localparam logic [ModeWidth-1:0] ModeHalfAway = 4'd7;
  localparam logic [ModeWidth-1:0] ModeHalfEven = 4'd8;
  localparam logic [ModeWidth-1:0] ModeHalfOdd  = 4'd9;

  // fraction class of the discarded part
  typedef enum logic [1:0] {
    FracZero  = 2'd0,
    FracBelow = 2'd1,
    FracHalf  = 2'd2,
    FracAbove = 2'd3
  } frac_e;

endpackage

### rtl/dtir_if.sv
// Valid/ready channel carrying a generic payload word.
// Uses no package.
interface dtir_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/double_to_int_rounding_modes.sv
// Double-to-integer converter with ten rounding modes: a four-stage pipeline.
// Depends on dtir_pkg and dtir_if.
//
// Takes one binary64 word and a mode per cycle while no stall backs up to the
// input, and returns one signed RESULT_WIDTH-bit integer with an invalid flag.
// The four register stages lie between the accepted word and the result. The
// pipeline accepts a word every cycle unless a stall has filled it. Each stage
// holds while its successor is full and stalled. Stage 1 decodes, stage 2
// aligns with a left or right shift, stage 3 classifies the fraction and
// rounds, and stage 4 saturates and negates. NaN gives 0. Infinity and
// overflow give the limit of the input's sign.
module double_to_int_rounding_modes #(
  parameter int unsigned RESULT_WIDTH = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  dtir_if.sink   in_i,
  dtir_if.source out_o
);
  import dtir_pkg::*;

  localparam int unsigned RW = RESULT_WIDTH;
  // magnitude needs RW bits (plus one for the rounding carry)
  localparam int unsigned MW = RW + 1;
  // max shift left kept: sig << 10 fits 63 bits
  localparam int unsigned AW = 64;

  // ---------------- pipeline control
  logic [3:0] vld_q;
  logic [3:0] adv;
  assign adv[3] = !vld_q[3] || out_o.ready;
  assign adv[2] = !vld_q[2] || adv[3];
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];
  assign in_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_i.valid;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
      if (adv[3]) vld_q[3] <= vld_q[2];
    end
  end

  // ---------------- stage 1: decode
  logic [ValueWidth-1:0] bits_w;
  logic [ModeWidth-1:0]  mode_w;
  assign bits_w = in_i.data.value_bits;
  assign mode_w = in_i.data.mode;

  logic                 s1_neg_q, s1_nan_q, s1_inf_q, s1_big_q;
  logic [ModeWidth-1:0] s1_mode_q;
  logic [SigWidth-1:0]  s1_sig_q;
  logic [ExpWidth-1:0]  s1_ex_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_neg_q  <= bits_w[63];
      s1_mode_q <= mode_w;
      s1_ex_q   <= bits_w[62:52];
      s1_nan_q  <= (bits_w[62:52] == '1) && (bits_w[ManWidth-1:0] != '0);
      s1_inf_q  <= (bits_w[62:52] == '1) && (bits_w[ManWidth-1:0] == '0);
      // shift >= 11 with nonzero significand: always overflows
      s1_big_q  <= (bits_w[62:52] != '1) && (bits_w[62:52] >= 11'd1086);
      s1_sig_q  <= {(bits_w[62:52] != '0), bits_w[ManWidth-1:0]};
    end
  end

  // ---------------- stage 2: align
  // fixed point value: integer part in hi, discarded bits in lo
  logic [AW-1:0] s2_int_d, s2_rem_d;
  logic          s2_sticky_d;
  logic [AW-1:0] s2_int_q;
  logic          s2_rh_q, s2_rs_q;
  logic          s2_neg_q, s2_nan_q, s2_inf_q, s2_big_q;
  logic [ModeWidth-1:0] s2_mode_q;

  always_comb begin
    logic [10:0]  k;
    logic [127:0] wide;
    s2_int_d    = '0;
    s2_rem_d    = '0;
    s2_sticky_d = 1'b0;
    k           = '0;
    wide        = '0;
    if (s1_ex_q >= 11'd1075) begin
      s2_int_d = {11'd0, s1_sig_q} << (s1_ex_q - 11'd1075);
    end else begin
      // right shift by 1075-ex (subnormals use 1074)
      k = (s1_ex_q == '0) ? 11'd1074 : (11'd1075 - s1_ex_q);
      if (k >= 11'd64) begin
        s2_sticky_d = (s1_sig_q != '0);
      end else begin
        wide     = {11'd0, s1_sig_q, 64'd0} >> k[5:0];
        s2_int_d = wide[127:64];
        s2_rem_d = wide[63:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_int_q  <= s2_int_d;
      s2_rh_q   <= s2_rem_d[63];
      s2_rs_q   <= (s2_rem_d[62:0] != '0) || s2_sticky_d;
      s2_neg_q  <= s1_neg_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_big_q  <= s1_big_q;
      s2_mode_q <= s1_mode_q;
    end
  end

  // ---------------- stage 3: classify and round
  frac_e        frac_w;
  logic         bump_w;
  logic [AW:0]  s2_ext_w;
  logic         s3_neg_q, s3_nan_q, s3_inf_q, s3_ovf_q;
  logic [MW-1:0] s3_mag_q;

  assign s2_ext_w = {1'b0, s2_int_q};

  always_comb begin
    unique case ({s2_rh_q, s2_rs_q})
      2'b00:   frac_w = FracZero;
      2'b01:   frac_w = FracBelow;
      2'b10:   frac_w = FracHalf;
      default: frac_w = FracAbove;
    endcase
  end

  always_comb begin
    logic inexact, nearest_tie;
    inexact     = (frac_w != FracZero);
    nearest_tie = 1'b0;
    unique case (s2_mode_q)
      ModeHalfUp:   nearest_tie = !s2_neg_q;
      ModeHalfDown: nearest_tie = s2_neg_q;
      ModeHalfZero: nearest_tie = 1'b0;
      ModeHalfAway: nearest_tie = 1'b1;
      ModeHalfEven: nearest_tie = s2_int_q[0];
      ModeHalfOdd:  nearest_tie = !s2_int_q[0];
      default:      nearest_tie = 1'b0;
    endcase
    case (s2_mode_q) inside
      ModeFloor: bump_w = s2_neg_q && inexact;
      ModeCeil:  bump_w = !s2_neg_q && inexact;
      ModeAway:  bump_w = inexact;
      ModeHalfUp, ModeHalfDown, ModeHalfZero, ModeHalfAway, ModeHalfEven,
      ModeHalfOdd:
        bump_w = (frac_w == FracAbove) || ((frac_w == FracHalf) && nearest_tie);
      default:   bump_w = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_mag_q <= s2_ext_w[MW-1:0] + MW'(bump_w);
      // integer part at or above 2^RW: out of range, and the carry bit stays free
      s3_ovf_q <= s2_big_q || (s2_ext_w[AW:RW] != '0);
      s3_neg_q <= s2_neg_q;
      s3_nan_q <= s2_nan_q;
      s3_inf_q <= s2_inf_q;
    end
  end

  // ---------------- stage 4: saturate and sign
  localparam logic [MW-1:0] TopMag = MW'(1) << (RW - 1);
  logic          ovf_w;
  logic [RW-1:0] res_w;
  logic          inv_w;
  logic [RW-1:0] s4_res_q;
  logic          s4_inv_q;

  always_comb begin
    logic [MW-1:0] neg_mag;
    neg_mag = '0 - s3_mag_q;
    ovf_w = s3_ovf_q ||
            (s3_neg_q ? (s3_mag_q > TopMag) : (s3_mag_q > (TopMag - MW'(1))));
    inv_w = s3_nan_q || s3_inf_q || ovf_w;
    if (s3_nan_q) begin
      res_w = '0;
    end else if (s3_inf_q || ovf_w) begin
      res_w = s3_neg_q ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
    end else begin
      res_w = s3_neg_q ? neg_mag[RW-1:0] : s3_mag_q[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_res_q <= res_w;
      s4_inv_q <= inv_w;
    end
  end

  assign out_o.valid        = vld_q[3];
  assign out_o.data.rounded = s4_res_q;
  assign out_o.data.invalid = s4_inv_q;

  // ---------------- assertions
  a_hold_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.data.rounded))
    else $error("output word changed while stalled");
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) |-> in_i.ready)
    else $error("empty pipeline not ready");
  a_nan_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_nan_q && vld_q[2] && adv[3] |=> (s4_res_q == '0) && s4_inv_q)
    else $error("NaN did not give zero with invalid");

endmodule

### verif/dtir_tb_types.sv
`timescale 1ns / 1ps
// Payload types for the double-to-integer rounding testbench.
// Depends on dtir_pkg.
package dtir_tb_types;
  import dtir_pkg::*;

  typedef struct packed {
    logic [ValueWidth-1:0] value_bits;
    logic [ModeWidth-1:0]  mode;
  } conv_in_t;

  typedef struct packed {
    logic signed [31:0] rounded;
    logic               invalid;
  } conv_out_t;
endpackage

### verif/double_to_int_rounding_modes_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for double_to_int_rounding_modes: directed table, then random
// operands with random gaps and stalls, checked against an exact software predictor.
// Depends on dtir_pkg, dtir_tb_types, dtir_if and the RTL top.
module double_to_int_rounding_modes_tb;
  import dtir_pkg::*;
  import dtir_tb_types::*;

  localparam int NumRandom = 1300;
  localparam int CycleLimit = 200000;
  localparam logic [63:0] PosInf = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] QNan   = 64'h7FF8_0000_0000_0001;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_invalid = 0;
  bit   stall_long = 1'b0;
  bit   sent_all = 1'b0;

  dtir_if #(.payload_t(conv_in_t))  in_ch ();
  dtir_if #(.payload_t(conv_out_t)) out_ch ();

  double_to_int_rounding_modes #(.RESULT_WIDTH(32)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // directed row: operand, mode, and an optional hand-written result
  typedef struct {
    logic [63:0]        value_bits;
    logic [3:0]         mode;
    bit                 typed;
    logic signed [31:0] rounded;
    logic               invalid;
  } row_t;

  conv_out_t expected_words[$];

  // exact conversion of a binary64 word with the given rounding mode
  function automatic conv_out_t convert_double(logic [63:0] bits, logic [3:0] mode);
    conv_out_t   r;
    logic        neg;
    logic [10:0] ex;
    logic [52:0] sig;
    logic [63:0] mag;
    logic [63:0] rem;
    logic [63:0] half;
    frac_e       frac;
    int          shift;
    int          k;
    bit          ovf;
    bit          bump;
    bit          inexact;
    neg = bits[63];
    ex = bits[62:52];
    sig = (ex == 0) ? {1'b0, bits[51:0]} : {1'b1, bits[51:0]};
    mag = '0;
    frac = FracZero;
    ovf = 1'b0;
    r.invalid = 1'b0;
    if (ex == 11'h7FF) begin
      r.invalid = 1'b1;
      r.rounded = (bits[51:0] != 0) ? 32'sd0 : (neg ? 32'h8000_0000 : 32'h7FFF_FFFF);
      return r;
    end
    shift = (ex == 0) ? -1074 : int'(ex) - 1075;
    if (shift >= 0) begin
      if (shift >= 11) ovf = (sig != 0);
      else mag = 64'(sig) << shift;
    end else begin
      k = -shift;
      if (k >= 64) begin
        frac = (sig != 0) ? FracBelow : FracZero;
      end else begin
        half = 64'd1 << (k - 1);
        rem = 64'(sig) & ((half << 1) - 1);
        mag = 64'(sig) >> k;
        if (rem == 0) frac = FracZero;
        else if (rem < half) frac = FracBelow;
        else if (rem == half) frac = FracHalf;
        else frac = FracAbove;
      end
    end
    if (!ovf) begin
      inexact = (frac != FracZero);
      case (mode) inside
        ModeFloor: bump = neg && inexact;
        ModeCeil:  bump = !neg && inexact;
        ModeAway:  bump = inexact;
        ModeHalfUp, ModeHalfDown, ModeHalfZero, ModeHalfAway, ModeHalfEven,
        ModeHalfOdd: begin
          if (frac == FracAbove) bump = 1'b1;
          else if (frac != FracHalf) bump = 1'b0;
          else begin
            case (mode)
              ModeHalfUp:   bump = !neg;
              ModeHalfDown: bump = neg;
              ModeHalfZero: bump = 1'b0;
              ModeHalfAway: bump = 1'b1;
              ModeHalfEven: bump = mag[0];
              default:      bump = !mag[0];
            endcase
          end
        end
        default: bump = 1'b0;  // toward zero, also for undefined codes
      endcase
      if (bump) mag = mag + 1;
      if (neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF)) ovf = 1'b1;
    end
    if (ovf) begin
      r.invalid = 1'b1;
      r.rounded = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r.rounded = neg ? 32'(-mag) : mag[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h (word %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  // random operand, biased towards values near the int32 range and towards ties
  function automatic logic [63:0] random_double();
    logic [63:0] v;
    int          pick;
    v = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 6) v[62:52] = 11'(1023 + $urandom_range(0, 33) - 2);
    else if (pick == 6) v[62:52] = 11'($urandom_range(1000, 1022));
    else if (pick == 7) v[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
    if ($urandom_range(0, 3) == 0) v[30:0] = '0;  // often exact or a tie
    if ($urandom_range(0, 7) == 0) v[51:0] = 52'h8_0000_0000_0000 >> $urandom_range(0, 40);
    return v;
  endfunction

  // valid drops only when a gap follows, so back-to-back words keep it high
  task automatic send_word(logic [63:0] v, logic [3:0] m);
    conv_in_t w;
    int       gap;
    gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    w.value_bits = v;
    w.mode = m;
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    expected_words.push_back(convert_double(v, m));
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    row_t rows[$];
    logic [63:0] v;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    rows = '{
      '{64'h0000_0000_0000_0000, ModeHalfUp,   1, 32'sd0, 1'b0},
      '{64'h8000_0000_0000_0000, ModeCeil,     1, 32'sd0, 1'b0},
      '{QNan,                    ModeFloor,    1, 32'sd0, 1'b1},
      '{64'hFFFF_FFFF_FFFF_FFFF, ModeAway,     1, 32'sd0, 1'b1},
      '{PosInf,                  ModeTrunc,    1, 32'h7FFF_FFFF, 1'b1},
      '{PosInf | 64'h8000_0000_0000_0000, ModeHalfEven, 1, 32'h8000_0000, 1'b1},
      '{64'h41DF_FFFF_FFC0_0000, ModeHalfUp,   1, 32'h7FFF_FFFF, 1'b0},
      '{64'h41E0_0000_0000_0000, ModeFloor,    1, 32'h7FFF_FFFF, 1'b1},
      '{64'hC1E0_0000_0000_0000, ModeCeil,     1, 32'h8000_0000, 1'b0},
      '{64'hC1E0_0000_0020_0000, ModeAway,     1, 32'h8000_0000, 1'b1},
      '{64'h41DF_FFFF_FFE0_0000, ModeHalfAway, 1, 32'h7FFF_FFFF, 1'b1},
      '{64'h3FE0_0000_0000_0000, ModeHalfUp,   0, 0, 0},
      '{64'hBFE0_0000_0000_0000, ModeHalfDown, 0, 0, 0},
      '{64'h4004_0000_0000_0000, ModeHalfZero, 0, 0, 0},
      '{64'hC004_0000_0000_0000, ModeHalfAway, 0, 0, 0},
      '{64'h4004_0000_0000_0000, ModeHalfEven, 0, 0, 0},
      '{64'h400C_0000_0000_0000, ModeHalfOdd,  0, 0, 0},
      '{64'h3FF8_0000_0000_0000, 4'd10,        0, 0, 0},
      '{64'hBFF8_0000_0000_0000, 4'd15,        0, 0, 0},
      '{64'h0000_0000_0000_0001, ModeCeil,     0, 0, 0},
      '{64'h800F_FFFF_FFFF_FFFF, ModeFloor,    0, 0, 0},
      '{64'h7FEF_FFFF_FFFF_FFFF, ModeHalfUp,   0, 0, 0},
      '{64'h3FDF_FFFF_FFFF_FFFF, ModeHalfAway, 0, 0, 0},
      '{64'hC00B_FFFF_FFFF_FFFF, ModeTrunc,    0, 0, 0}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // typed rows cross-check the predictor itself
    foreach (rows[i]) begin
      if (rows[i].typed) begin
        conv_out_t p;
        p = convert_double(rows[i].value_bits, rows[i].mode);
        if (p.rounded !== rows[i].rounded || p.invalid !== rows[i].invalid)
          report_mismatch("table row", {p.rounded, 31'b0, p.invalid},
                          {rows[i].rounded, 31'b0, rows[i].invalid});
      end
      send_word(rows[i].value_bits, rows[i].mode);
    end
    for (int n = 0; n < NumRandom; n++) begin
      if (n == 300) stall_long = 1'b1;
      v = random_double();
      send_word(v, 4'($urandom_range(0, 15)));
    end
    in_ch.valid <= 1'b0;
    sent_all = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_long) begin
        stall_long = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
      end
      wait_n = $urandom_range(0, 2) ? 0 : $urandom_range(0, 6);
      if (wait_n != 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    conv_out_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_ch.data), 64'd0);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.data.rounded !== want.rounded)
          report_mismatch("rounded", 64'(out_ch.data.rounded), 64'(want.rounded));
        if (out_ch.data.invalid !== want.invalid)
          report_mismatch("invalid", 64'(out_ch.data.invalid), 64'(want.invalid));
        if (want.invalid) n_invalid++;
      end
      n_checked++;
    end
  end

  // end of run and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    wait (sent_all);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("converted %0d words across all rounding codes, %0d flagged invalid",
             n_checked, n_invalid);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
